// ===== sv/ewp_pkg.sv =====
package ewp_pkg;

    localparam int MAX_WINDOW_DEF = 32;

    localparam int TIME_W     = 63;
    localparam int COORD_W    = 16;
    localparam int INTERVAL_W = 40;
    localparam int WINDOW_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int STAMP_W    = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 2'd2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 40'd10000;
    localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 6'd32;

    typedef struct packed {
        logic [TIME_W-1:0]  ev_time;
        logic [COORD_W-1:0] ev_x;
        logic [COORD_W-1:0] ev_y;
        logic               ev_polarity;
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

endpackage

// ===== sv/event_window_packetizer.sv =====
// an event that triggers no packet gives no transfer
// a triggering event with k earlier events in its window gives k+1 transfers,
// each a history ram read, then an output register load, which output stalls hold
// throughput: one event per cycle between packets; no event is taken during readout
// reset: aresetn synchronous active low, clears state, counters, pointers, m_valid;
// config gets defaults; ram and payload regs not cleared, only written entries are read
module event_window_packetizer #(
    parameter int MAX_WINDOW = ewp_pkg::MAX_WINDOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [ewp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ewp_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ewp_pkg::TIME_W-1:0]      s_event_time,
    input  logic [ewp_pkg::COORD_W-1:0]     s_event_x,
    input  logic [ewp_pkg::COORD_W-1:0]     s_event_y,
    input  logic                            s_event_polarity,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ewp_pkg::TIME_W-1:0]      m_packet_stamp,
    output logic [ewp_pkg::TIME_W-1:0]      m_out_time,
    output logic [ewp_pkg::COORD_W-1:0]     m_out_x,
    output logic [ewp_pkg::COORD_W-1:0]     m_out_y,
    output logic                            m_out_polarity,
    output logic                            m_packet_last
);

    localparam int DEPTH = MAX_WINDOW + 1;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (PTR_W > ewp_pkg::WINDOW_W) ? PTR_W : ewp_pkg::WINDOW_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] MAX_HELD  = PTR_W'(MAX_WINDOW);
    localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_WINDOW);

    // configuration
    logic                               time_mode_reg;
    logic [ewp_pkg::INTERVAL_W-1:0]     interval_reg;
    logic [ewp_pkg::WINDOW_W-1:0]       window_reg;

    // history ram
    ewp_pkg::event_t                    mem [DEPTH];
    ewp_pkg::event_t                    wr_data;
    ewp_pkg::event_t                    rd_data_reg;
    logic                               wr_en;

    // control state
    ewp_pkg::state_t                    state_reg, state_next;
    logic [PTR_W-1:0]                   wp_reg, wp_next;
    logic [PTR_W-1:0]                   held_reg, held_next;
    logic [ewp_pkg::INTERVAL_W-1:0]     dist_reg, dist_next;
    logic [ewp_pkg::STAMP_W-1:0]        lp1_reg, lp1_next;
    logic [PTR_W-1:0]                   addr_reg, addr_next;
    logic [PTR_W-1:0]                   cnt_reg, cnt_next;
    logic [ewp_pkg::TIME_W-1:0]         stamp_reg, stamp_next;
    logic                               m_valid_reg, m_valid_next;

    // output payload
    logic [ewp_pkg::TIME_W-1:0]         o_stamp_reg, o_stamp_next;
    ewp_pkg::event_t                    o_ev_reg, o_ev_next;
    logic                               o_last_reg, o_last_next;

    // trigger decision
    logic                               fire;
    logic [ewp_pkg::STAMP_W-1:0]        threshold;
    logic [CMP_W-1:0]                   win_eff;
    logic [PTR_W-1:0]                   k;
    logic [PTR_W:0]                     start_wide;
    logic [PTR_W-1:0]                   start_slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_mode_reg <= 1'b0;
            interval_reg  <= ewp_pkg::INTERVAL_RST;
            window_reg    <= ewp_pkg::WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ewp_pkg::REG_TIME_MODE:       time_mode_reg <= cfg_data[0];
                ewp_pkg::REG_PACKET_INTERVAL: interval_reg  <= cfg_data;
                ewp_pkg::REG_WINDOW_SIZE:     window_reg    <= cfg_data[ewp_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    assign wr_data = '{ev_time: s_event_time, ev_x: s_event_x, ev_y: s_event_y,
                       ev_polarity: s_event_polarity};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign threshold = lp1_reg + {{(ewp_pkg::STAMP_W-ewp_pkg::INTERVAL_W){1'b0}}, interval_reg};

    always_comb begin
        if (time_mode_reg) begin
            fire = {1'b0, s_event_time} >= threshold;
        end else begin
            fire = dist_reg >= interval_reg;
        end
        win_eff = (CMP_W'(window_reg) > MAX_CMP) ? MAX_CMP : CMP_W'(window_reg);
        k = (CMP_W'(held_reg) < win_eff) ? held_reg : win_eff[PTR_W-1:0];
        if (wp_reg >= k) begin
            start_wide = {1'b0, wp_reg} - {1'b0, k};
        end else begin
            start_wide = {1'b0, wp_reg} + (PTR_W+1)'(DEPTH) - {1'b0, k};
        end
        start_slot = start_wide[PTR_W-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        held_next    = held_reg;
        dist_next    = dist_reg;
        lp1_next     = lp1_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        stamp_next   = stamp_reg;
        m_valid_next = m_valid_reg;
        o_stamp_next = o_stamp_reg;
        o_ev_next    = o_ev_reg;
        o_last_next  = o_last_reg;

        s_ready = (state_reg == ewp_pkg::ST_IDLE);
        wr_en   = s_valid && s_ready;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ewp_pkg::ST_IDLE: begin
                if (wr_en) begin
                    wp_next = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
                    if (held_reg < MAX_HELD) begin
                        held_next = held_reg + 1'b1;
                    end
                    if (fire) begin
                        stamp_next = s_event_time;
                        lp1_next   = {1'b0, s_event_time} + ewp_pkg::STAMP_W'(1);
                        dist_next  = ewp_pkg::INTERVAL_W'(1);
                        cnt_next   = k;
                        addr_next  = start_slot;
                        state_next = ewp_pkg::ST_READ;
                    end else if (dist_reg != '1) begin
                        dist_next = dist_reg + 1'b1;
                    end
                end
            end
            ewp_pkg::ST_READ: begin
                state_next = ewp_pkg::ST_LOAD;
            end
            ewp_pkg::ST_LOAD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_stamp_next = stamp_reg;
                    o_ev_next    = rd_data_reg;
                    o_last_next  = (cnt_reg == '0);
                    if (cnt_reg == '0) begin
                        state_next = ewp_pkg::ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg - 1'b1;
                        addr_next  = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
                        state_next = ewp_pkg::ST_READ;
                    end
                end
            end
            default: state_next = ewp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ewp_pkg::ST_IDLE;
            wp_reg      <= '0;
            held_reg    <= '0;
            dist_reg    <= '0;
            lp1_reg     <= '0;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            held_reg    <= held_next;
            dist_reg    <= dist_next;
            lp1_reg     <= lp1_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stamp_reg   <= stamp_next;
        o_stamp_reg <= o_stamp_next;
        o_ev_reg    <= o_ev_next;
        o_last_reg  <= o_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_packet_stamp = o_stamp_reg;
    assign m_out_time     = o_ev_reg.ev_time;
    assign m_out_x        = o_ev_reg.ev_x;
    assign m_out_y        = o_ev_reg.ev_y;
    assign m_out_polarity = o_ev_reg.ev_polarity;
    assign m_packet_last  = o_last_reg;

endmodule

// ===== sim/packet_checker.sv =====
module packet_checker
    import ewp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [TIME_W-1:0]      s_event_time,
    input  logic [COORD_W-1:0]     s_event_x,
    input  logic [COORD_W-1:0]     s_event_y,
    input  logic                   s_event_polarity,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [TIME_W-1:0]      m_packet_stamp,
    input  logic [TIME_W-1:0]      m_out_time,
    input  logic [COORD_W-1:0]     m_out_x,
    input  logic [COORD_W-1:0]     m_out_y,
    input  logic                   m_out_polarity,
    input  logic                   m_packet_last,

    output int                     mismatch_count,
    output int                     members_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = MAX_WINDOW_DEF + 1;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [TIME_W-1:0]  ev_time;
        logic [COORD_W-1:0] ev_x;
        logic [COORD_W-1:0] ev_y;
        logic               ev_polarity;
        logic               last;
    } member_t;

    member_t                expected_members[$];
    event_t                 recent_events[0:RING_DEPTH-1];
    int unsigned            ring_head;
    int unsigned            ring_fill;
    logic [INTERVAL_W-1:0]  since_packet;
    logic [STAMP_W-1:0]     prev_stamp;

    logic                   cfg_time_mode;
    logic [INTERVAL_W-1:0]  cfg_interval;
    logic [WINDOW_W-1:0]    cfg_window;

    task automatic clear_state();
        ring_head     = 0;
        ring_fill     = 0;
        since_packet  = '0;
        prev_stamp    = '1;
        cfg_time_mode = 1'b0;
        cfg_interval  = INTERVAL_RST;
        cfg_window    = WINDOW_RST;
        expected_members.delete();
        mismatch_count = 0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_TIME_MODE:       cfg_time_mode = value[0];
            REG_PACKET_INTERVAL: cfg_interval  = value[INTERVAL_W-1:0];
            REG_WINDOW_SIZE:     cfg_window    = value[WINDOW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_packet(input event_t ev);
        logic        due;
        int unsigned span;
        int unsigned earlier;
        int unsigned slot;
        member_t     m;
        recent_events[ring_head] = ev;
        if (cfg_time_mode) begin
            due = ({1'b0, ev.ev_time} + 64'd1) >
                  (prev_stamp + 64'd1 + {{(STAMP_W-INTERVAL_W){1'b0}}, cfg_interval});
        end else begin
            due = since_packet >= cfg_interval;
        end
        if (due) begin
            span    = (int'(cfg_window) > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(cfg_window);
            earlier = (ring_fill < span) ? ring_fill : span;
            for (int j = 0; j <= earlier; j++) begin
                slot          = (ring_head + RING_DEPTH - earlier + j) % RING_DEPTH;
                m.stamp       = ev.ev_time;
                m.ev_time     = recent_events[slot].ev_time;
                m.ev_x        = recent_events[slot].ev_x;
                m.ev_y        = recent_events[slot].ev_y;
                m.ev_polarity = recent_events[slot].ev_polarity;
                m.last        = (j == earlier);
                expected_members = {expected_members, m};
            end
            prev_stamp   = {1'b0, ev.ev_time};
            since_packet = INTERVAL_W'(1);
        end else if (since_packet != '1) begin
            since_packet = since_packet + 1'b1;
        end
        ring_head = (ring_head + 1) % RING_DEPTH;
        if (ring_fill < MAX_WINDOW_DEF) ring_fill++;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_member();
        member_t want;
        if (expected_members.size() == 0) begin
            $error("result transfer with no expected packet member, out_time %0h",
                   m_out_time);
            mismatch_count++;
        end else begin
            want = expected_members.pop_front();
            check_field("packet_stamp", 64'(want.stamp), 64'(m_packet_stamp));
            check_field("out_time", 64'(want.ev_time), 64'(m_out_time));
            check_field("out_x", 64'(want.ev_x), 64'(m_out_x));
            check_field("out_y", 64'(want.ev_y), 64'(m_out_y));
            check_field("out_polarity", 64'(want.ev_polarity), 64'(m_out_polarity));
            check_field("packet_last", 64'(want.last), 64'(m_packet_last));
        end
    endtask

    always @(posedge aclk) begin
        event_t taken;
        if (!aresetn) begin
            clear_state();
        end else begin
            if (m_valid && m_ready) check_member();
            if (cfg_wr_en) apply_write(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                taken = {s_event_time, s_event_x, s_event_y, s_event_polarity};
                predict_packet(taken);
            end
        end
        members_pending <= expected_members.size();
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import ewp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [TIME_W-1:0]      s_event_time;
    logic [COORD_W-1:0]     s_event_x;
    logic [COORD_W-1:0]     s_event_y;
    logic                   s_event_polarity;
    logic                   m_valid;
    logic                   m_ready;
    logic [TIME_W-1:0]      m_packet_stamp;
    logic [TIME_W-1:0]      m_out_time;
    logic [COORD_W-1:0]     m_out_x;
    logic [COORD_W-1:0]     m_out_y;
    logic                   m_out_polarity;
    logic                   m_packet_last;

    int                     mismatch_count;
    int                     members_pending;
    int                     send_idle_pct = 25;
    int                     recv_idle_pct = 75;
    int                     hold_cycles = 0;
    int                     cycle_count = 0;
    logic [TIME_W-1:0]      top_time = '0;

    event_window_packetizer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_event_time     (s_event_time),
        .s_event_x        (s_event_x),
        .s_event_y        (s_event_y),
        .s_event_polarity (s_event_polarity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_stamp   (m_packet_stamp),
        .m_out_time       (m_out_time),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_polarity   (m_out_polarity),
        .m_packet_last    (m_packet_last)
    );

    packet_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_event_time     (s_event_time),
        .s_event_x        (s_event_x),
        .s_event_y        (s_event_y),
        .s_event_polarity (s_event_polarity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_stamp   (m_packet_stamp),
        .m_out_time       (m_out_time),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_polarity   (m_out_polarity),
        .m_packet_last    (m_packet_last),
        .mismatch_count   (mismatch_count),
        .members_pending  (members_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("event_window_packetizer: mismatch");
        $finish;
    end

    function automatic event_t make_event(input logic [TIME_W-1:0] t,
                                          input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic pol);
        event_t ev;
        ev.ev_time     = t;
        ev.ev_x        = x;
        ev.ev_y        = y;
        ev.ev_polarity = pol;
        return ev;
    endfunction

    function automatic event_t random_event(input logic [TIME_W-1:0] t);
        return make_event(t, 16'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    task automatic send_event(input event_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_event_time     <= ev.ev_time;
        s_event_x        <= ev.ev_x;
        s_event_y        <= ev.ev_y;
        s_event_polarity <= ev.ev_polarity;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (ev.ev_time > top_time) top_time = ev.ev_time;
    endtask

    // quiet input, wait for all members, then let a last silent event settle
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (members_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic configure(input logic by_time, input logic [INTERVAL_W-1:0] ival,
                             input logic [WINDOW_W-1:0] win);
        write_reg(REG_TIME_MODE, CFG_DATA_W'(by_time));
        write_reg(REG_PACKET_INTERVAL, CFG_DATA_W'(ival));
        write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(input int count, input bit long_hold);
        logic                  by_time;
        logic [INTERVAL_W-1:0] ival;
        logic [WINDOW_W-1:0]   win;
        logic [TIME_W-1:0]     now;
        logic [63:0]           step;
        drain_results();
        by_time = 1'($urandom_range(1));
        if (by_time) begin
            case ($urandom_range(5))
                0:       ival = '0;
                4:       ival = {8'($urandom), 32'($urandom)};
                5:       ival = '1;
                default: ival = INTERVAL_W'($urandom_range(1, 1000));
            endcase
        end else begin
            case ($urandom_range(11))
                0, 1:    ival = '0;
                2:       ival = INTERVAL_W'($urandom_range(10, 40));
                3:       ival = '1;
                default: ival = INTERVAL_W'($urandom_range(1, 6));
            endcase
        end
        if (long_hold) begin
            by_time = 1'b0;
            ival    = INTERVAL_W'(2);
        end
        case ($urandom_range(5))
            0:       win = '0;
            1:       win = 6'd32;
            2:       win = '1;
            default: win = WINDOW_W'($urandom_range(1, 40));
        endcase
        configure(by_time, ival, win);
        if (long_hold) hold_cycles = 400;
        now = top_time;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain_results();
            if (by_time) begin
                step = 64'(ival >> 2) * $urandom_range(0, 8) + $urandom_range(0, 3);
                if ($urandom_range(19) == 0 && 64'(now) >= step) begin
                    now = now - TIME_W'(step);
                end else begin
                    now = now + TIME_W'(step);
                end
            end else begin
                now = TIME_W'({$urandom_range(32'h1fff_ffff), $urandom});
            end
            send_event(random_event(now));
        end
    endtask

    initial begin
        aresetn          <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= REG_TIME_MODE;
        cfg_data         <= '0;
        s_valid          <= 1'b0;
        s_event_time     <= '0;
        s_event_x        <= '0;
        s_event_y        <= '0;
        s_event_polarity <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every event fires, window above the ring size
        configure(1'b0, '0, '1);
        send_event(make_event('1, '1, '1, 1'b1));
        top_time = '0;
        send_event(make_event('0, '0, '0, 1'b0));
        send_event(make_event(63'd5, 16'h5555, 16'haaaa, 1'b1));
        send_event(make_event(63'd9, 16'haaaa, 16'h5555, 1'b0));

        drain_results();
        configure(1'b0, 40'd3, 6'd2);
        for (int i = 0; i < 8; i++) send_event(random_event(63'(10 + i)));

        // elapsed time trigger: equal, stepping back, strictly past the interval
        drain_results();
        configure(1'b1, 40'd100, 6'd5);
        send_event(random_event(63'd200));
        send_event(random_event(63'd250));
        send_event(random_event(63'd300));
        send_event(random_event(63'd301));
        send_event(random_event(63'd150));
        send_event(random_event(63'd401));
        send_event(random_event(63'd402));
        send_event(random_event(63'd402));

        drain_results();
        configure(1'b0, '1, '0);
        for (int i = 0; i < 3; i++) send_event(random_event(63'(500 + i)));

        drain_results();
        configure(1'b0, 40'd1, '0);
        send_event(random_event(63'd600));
        send_event(random_event(63'd601));

        for (int pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 3; ph++) run_random_phase(14, pass == 2 && ph == 1);
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && members_pending == 0) begin
            $display("event_window_packetizer: match");
        end else begin
            $display("event_window_packetizer: mismatch");
        end
        $finish;
    end

endmodule
